// File: sv/tbf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbf_pkg
// Shared constants, control word layout and microcode program of the
// three-channel biquad filter.
// ----------------------------------------------------------------------------
package tbf_pkg;

	localparam int FRAC_BITS  = 16;
	localparam int SAMPLE_W   = 24;
	localparam int AXIS_W     = 2;
	localparam int WORD_W     = 32;
	localparam int REGS       = 5;
	localparam int REG_IDX_W  = 3;
	localparam int ADDR_W     = 5;
	localparam int APB_DW     = 32;
	localparam int COEF_MIN_W = 18;
	localparam int B0_RESET   = 65536;

	// register indexes
	localparam logic [REG_IDX_W-1:0] REG_A1 = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_A2 = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_B0 = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_B1 = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_B2 = 3'd4;

	// multiplier word select
	localparam logic [1:0] WORD_W1 = 2'd0;
	localparam logic [1:0] WORD_W2 = 2'd1;
	localparam logic [1:0] WORD_W0 = 2'd2;

	// accumulator operations
	localparam logic [1:0] ACC_HOLD   = 2'd0;
	localparam logic [1:0] ACC_LOAD_X = 2'd1;
	localparam logic [1:0] ACC_ADD    = 2'd2;
	localparam logic [1:0] ACC_LOAD_P = 2'd3;

	// jump conditions
	localparam logic [1:0] COND_NONE     = 2'd0;
	localparam logic [1:0] COND_NO_ITEM  = 2'd1;
	localparam logic [1:0] COND_OUT_BUSY = 2'd2;

	// program steps
	localparam int PC_W = 3;
	localparam logic [PC_W-1:0] STEP_WAIT = 3'd0;
	localparam logic [PC_W-1:0] STEP_FB1  = 3'd1;
	localparam logic [PC_W-1:0] STEP_FB2  = 3'd2;
	localparam logic [PC_W-1:0] STEP_FF1  = 3'd3;
	localparam logic [PC_W-1:0] STEP_FF2  = 3'd4;
	localparam logic [PC_W-1:0] STEP_FF0  = 3'd5;
	localparam logic [PC_W-1:0] STEP_ACC  = 3'd6;
	localparam logic [PC_W-1:0] STEP_OUT  = 3'd7;

	typedef struct packed {
		logic [REG_IDX_W-1:0] coef_sel;
		logic [1:0]           word_sel;
		logic [1:0]           acc_a_op;
		logic [1:0]           acc_b_op;
		logic                 w0_ld;
		logic                 delay_wr;
		logic                 out_ld;
		logic [1:0]           cond;
		logic                 last;
		logic [PC_W-1:0]      target;
	} ucode_t;

	function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
		ucode_t w;
		w = '0;
		case (pc)
			STEP_WAIT: begin
				w.cond   = COND_NO_ITEM;
				w.target = STEP_WAIT;
			end
			STEP_FB1: begin
				w.coef_sel = REG_A1;
				w.word_sel = WORD_W1;
				w.acc_a_op = ACC_LOAD_X;
			end
			STEP_FB2: begin
				w.coef_sel = REG_A2;
				w.word_sel = WORD_W2;
				w.acc_a_op = ACC_ADD;
			end
			STEP_FF1: begin
				w.coef_sel = REG_B1;
				w.word_sel = WORD_W1;
				w.acc_a_op = ACC_ADD;
			end
			STEP_FF2: begin
				w.coef_sel = REG_B2;
				w.word_sel = WORD_W2;
				w.w0_ld    = 1'b1;
				w.acc_b_op = ACC_LOAD_P;
			end
			STEP_FF0: begin
				w.coef_sel = REG_B0;
				w.word_sel = WORD_W0;
				w.acc_b_op = ACC_ADD;
				w.delay_wr = 1'b1;
			end
			STEP_ACC: begin
				w.acc_b_op = ACC_ADD;
			end
			STEP_OUT: begin
				w.out_ld = 1'b1;
				w.cond   = COND_OUT_BUSY;
				w.target = STEP_OUT;
				w.last   = 1'b1;
			end
			default: begin
				w.last = 1'b1;
			end
		endcase
		return w;
	endfunction

endpackage

// File: sv/tbf_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbf_in_if
// Sample channel: one accelerometer sample and its axis per item.
// ----------------------------------------------------------------------------
interface tbf_in_if;
	logic                                valid;
	logic                                ready;
	logic signed [tbf_pkg::SAMPLE_W-1:0] sample;
	logic [tbf_pkg::AXIS_W-1:0]          axis;

	modport source (output valid, output sample, output axis, input ready);
	modport sink (input valid, input sample, input axis, output ready);
endinterface

// File: sv/tbf_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbf_out_if
// Result channel: one filtered sample and its axis per item.
// ----------------------------------------------------------------------------
interface tbf_out_if;
	logic                              valid;
	logic                              ready;
	logic signed [tbf_pkg::WORD_W-1:0] filtered;
	logic [tbf_pkg::AXIS_W-1:0]        axis_out;

	modport source (output valid, output filtered, output axis_out, input ready);
	modport sink (input valid, input filtered, input axis_out, output ready);
endinterface

// File: sv/tbf_ucode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbf_ucode
// Step counter and program table; issues one control word per cycle and
// takes conditional jumps on item arrival and output backpressure.
// ----------------------------------------------------------------------------
module tbf_ucode (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	input  logic             out_busy,
	output tbf_pkg::ucode_t  ctrl,
	output logic             ready
);

	logic [tbf_pkg::PC_W-1:0] pc_q;
	logic [tbf_pkg::PC_W-1:0] pc_next;
	logic                     cond_hit;

	assign ctrl  = tbf_pkg::ucode_rom(pc_q);
	assign ready = (pc_q == tbf_pkg::STEP_WAIT);

	always_comb begin
		case (ctrl.cond)
			tbf_pkg::COND_NONE:     cond_hit = 1'b0;
			tbf_pkg::COND_NO_ITEM:  cond_hit = !item_valid;
			tbf_pkg::COND_OUT_BUSY: cond_hit = out_busy;
			default:                cond_hit = 1'b0;
		endcase
	end

	always_comb begin
		if (cond_hit) begin
			pc_next = ctrl.target;
		end else if (ctrl.last) begin
			pc_next = tbf_pkg::STEP_WAIT;
		end else begin
			pc_next = pc_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= tbf_pkg::STEP_WAIT;
		end else begin
			pc_q <= pc_next;
		end
	end

endmodule

// File: sv/tbf_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbf_datapath
// Shared multiplier, two accumulators, per-channel delay words and the
// result register, all steered by the control word.
// ----------------------------------------------------------------------------
module tbf_datapath #(
	parameter int CHANNELS = 3,
	parameter int CW       = 20
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  tbf_pkg::ucode_t                     ctrl,
	input  logic                                accept,
	input  logic signed [tbf_pkg::SAMPLE_W-1:0] sample,
	input  logic [tbf_pkg::AXIS_W-1:0]          axis,
	input  logic signed [CW-1:0]                coef [tbf_pkg::REGS],
	input  logic                                out_ready,
	output logic                                out_valid,
	output logic                                out_busy,
	output logic signed [tbf_pkg::WORD_W-1:0]   filtered,
	output logic [tbf_pkg::AXIS_W-1:0]          axis_out
);

	localparam int BANK_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int PW     = CW + tbf_pkg::WORD_W;
	localparam int AW     = PW + 2;
	localparam int FR     = tbf_pkg::FRAC_BITS;
	localparam logic signed [AW-1:0] ROUND_HALF = AW'(1) << (FR - 1);

	logic signed [tbf_pkg::WORD_W-1:0]   delay_first_q  [CHANNELS];
	logic signed [tbf_pkg::WORD_W-1:0]   delay_second_q [CHANNELS];
	logic signed [tbf_pkg::SAMPLE_W-1:0] sample_q;
	logic [tbf_pkg::AXIS_W-1:0]          axis_q;
	logic [BANK_W-1:0]                   bank;
	logic [BANK_W-1:0]                   bank_q;
	logic signed [tbf_pkg::WORD_W-1:0]   w1_q;
	logic signed [tbf_pkg::WORD_W-1:0]   w2_q;
	logic signed [tbf_pkg::WORD_W-1:0]   w0_q;
	logic signed [CW-1:0]                mul_coef;
	logic signed [tbf_pkg::WORD_W-1:0]   mul_word;
	logic signed [PW-1:0]                prod_s1;
	logic signed [AW-1:0]                acc_a_q;
	logic signed [AW-1:0]                acc_b_q;
	logic signed [tbf_pkg::WORD_W-1:0]   filtered_q;
	logic [tbf_pkg::AXIS_W-1:0]          axis_out_q;
	logic                                out_valid_q;
	logic                                out_load;

	function automatic logic signed [tbf_pkg::WORD_W-1:0] sat_round(
		input logic signed [AW-1:0] v
	);
		logic [AW-FR-32:0] top;
		logic signed [tbf_pkg::WORD_W-1:0] r;
		top = v[AW-1:FR+31];
		if ((&top) || !(|top)) begin
			r = v[FR+31:FR];
		end else if (v[AW-1]) begin
			r = {1'b1, {(tbf_pkg::WORD_W-1){1'b0}}};
		end else begin
			r = {1'b0, {(tbf_pkg::WORD_W-1){1'b1}}};
		end
		return r;
	endfunction

	// unknown axis falls back to bank 0
	always_comb begin
		if (int'(axis) < CHANNELS) begin
			bank = BANK_W'(axis);
		end else begin
			bank = '0;
		end
	end

	assign mul_coef = coef[ctrl.coef_sel];

	always_comb begin
		case (ctrl.word_sel)
			tbf_pkg::WORD_W1: mul_word = w1_q;
			tbf_pkg::WORD_W2: mul_word = w2_q;
			tbf_pkg::WORD_W0: mul_word = w0_q;
			default:          mul_word = w1_q;
		endcase
	end

	assign out_busy = out_valid_q && !out_ready;
	assign out_load = ctrl.out_ld && !out_busy;

	always_ff @(posedge clk) begin
		if (accept) begin
			sample_q <= sample;
			axis_q   <= axis;
			bank_q   <= bank;
			w1_q     <= delay_first_q[bank];
			w2_q     <= delay_second_q[bank];
		end
		prod_s1 <= mul_coef * mul_word;
		case (ctrl.acc_a_op)
			tbf_pkg::ACC_LOAD_X: acc_a_q <= (AW'(sample_q) <<< FR) + ROUND_HALF;
			tbf_pkg::ACC_ADD:    acc_a_q <= acc_a_q + AW'(prod_s1);
			tbf_pkg::ACC_LOAD_P: acc_a_q <= AW'(prod_s1) + ROUND_HALF;
			default:             acc_a_q <= acc_a_q;
		endcase
		case (ctrl.acc_b_op)
			tbf_pkg::ACC_LOAD_X: acc_b_q <= (AW'(sample_q) <<< FR) + ROUND_HALF;
			tbf_pkg::ACC_ADD:    acc_b_q <= acc_b_q + AW'(prod_s1);
			tbf_pkg::ACC_LOAD_P: acc_b_q <= AW'(prod_s1) + ROUND_HALF;
			default:             acc_b_q <= acc_b_q;
		endcase
		if (ctrl.w0_ld) begin
			w0_q <= sat_round(acc_a_q);
		end
		if (out_load) begin
			filtered_q <= sat_round(acc_b_q);
			axis_out_q <= axis_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				delay_first_q[i]  <= '0;
				delay_second_q[i] <= '0;
			end
		end else if (ctrl.delay_wr) begin
			delay_first_q[bank_q]  <= w0_q;
			delay_second_q[bank_q] <= w1_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign filtered  = filtered_q;
	assign axis_out  = axis_out_q;

endmodule

// File: sv/three_channel_biquad_filter_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// three_channel_biquad_filter_top
// Direct form II biquad with one state bank per accelerometer axis,
// coefficient registers on an APB port and a microcoded datapath.
//
//   channel   dir   payload               handshake
//   samples   in    sample[23:0], axis    valid / ready
//   results   out   filtered[31:0], axis  valid / ready
//   apb       in    coefficients a1..b2   psel / penable, pready tied high
//
// An item runs through one wait step plus seven steps that share a single
// multiplier for the five products, so one item is in flight at a time.
// The result register frees the input side while a result waits.
// A stalled result holds the last step until the register drains.
// Reset clears the delay words of every axis and loads b0 = 1.0.
// ----------------------------------------------------------------------------
module three_channel_biquad_filter_top #(
	parameter int CHANNELS   = 3,
	parameter int COEF_WIDTH = 20
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [tbf_pkg::ADDR_W-1:0]   paddr,
	input  logic [tbf_pkg::APB_DW-1:0]   pwdata,
	output logic [tbf_pkg::APB_DW-1:0]   prdata,
	output logic                         pready,
	tbf_in_if.sink                       samples,
	tbf_out_if.source                    results
);

	localparam int CW = (COEF_WIDTH > tbf_pkg::COEF_MIN_W) ? COEF_WIDTH : tbf_pkg::COEF_MIN_W;

	logic signed [CW-1:0]          coef_q [tbf_pkg::REGS];
	logic [tbf_pkg::REG_IDX_W-1:0] reg_idx;
	logic                          reg_hit;
	logic                          cfg_wr;
	tbf_pkg::ucode_t               ctrl;
	logic                          seq_ready;
	logic                          accept;
	logic                          out_busy;

	assign pready  = 1'b1;
	assign reg_idx = paddr[tbf_pkg::ADDR_W-1:2];
	assign reg_hit = (int'(reg_idx) < tbf_pkg::REGS);
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_comb begin
		if (reg_hit) begin
			prdata = tbf_pkg::APB_DW'(coef_q[reg_idx]);
		end else begin
			prdata = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < tbf_pkg::REGS; i++) begin
				coef_q[i] <= '0;
			end
			coef_q[tbf_pkg::REG_B0] <= CW'(tbf_pkg::B0_RESET);
		end else if (cfg_wr && reg_hit) begin
			coef_q[reg_idx] <= CW'(signed'(pwdata[COEF_WIDTH-1:0]));
		end
	end

	assign samples.ready = seq_ready;
	assign accept        = samples.valid && seq_ready;

	tbf_ucode u_ucode (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (samples.valid),
		.out_busy   (out_busy),
		.ctrl       (ctrl),
		.ready      (seq_ready)
	);

	tbf_datapath #(
		.CHANNELS (CHANNELS),
		.CW       (CW)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl),
		.accept    (accept),
		.sample    (samples.sample),
		.axis      (samples.axis),
		.coef      (coef_q),
		.out_ready (results.ready),
		.out_valid (results.valid),
		.out_busy  (out_busy),
		.filtered  (results.filtered),
		.axis_out  (results.axis_out)
	);

`ifndef SYNTHESIS
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !samples.ready)
		else $error("input ready right after an accepted item");

	a_delay_write_timing: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##5 ctrl.delay_wr)
		else $error("delay line not updated five steps after accept");

	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		samples.ready |-> (!ctrl.delay_wr && !ctrl.out_ld && !ctrl.w0_ld))
		else $error("datapath active while waiting for an item");
`endif

endmodule
